// ===== hdl/ftvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftvt_pkg
// Shared types, codes and tables of the FIX tag=value tokenizer: the item and
// result layouts, status and configuration codes, and the hot-tag lookup.
// ----------------------------------------------------------------------------
package ftvt_pkg;

  // One input item: a byte of the message line with its framing flags.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  // One result item: either a parsed field or the end-of-message status.
  typedef struct packed {
    logic        result_kind;
    logic [29:0] tag_number;
    logic [4:0]  hot_slot;
    logic [11:0] value_offset;
    logic [11:0] value_length;
    logic [2:0]  status_code;
    logic [11:0] prefix_length;
    logic [11:0] field_count;
    logic        last_result;
  } out_item_t;

  // Results made by one item, field first and status second.
  typedef struct packed {
    logic      fld_vld;
    logic      sts_vld;
    out_item_t fld;
    out_item_t sts;
  } push_t;

  // Result kinds.
  localparam logic KIND_FIELD  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_NO_START   = 3'd2;
  localparam logic [2:0] ST_NO_EQUALS  = 3'd3;
  localparam logic [2:0] ST_BAD_TAG    = 3'd4;
  localparam logic [2:0] ST_NO_TAGS    = 3'd5;
  localparam logic [2:0] ST_NO_MSGTYPE = 3'd6;

  // Configuration register indexes.
  localparam logic CFG_FIELD_DELIMITER = 1'b0;
  localparam logic CFG_REPORT_PREFIX   = 1'b1;

  // Characters the parser looks for.
  localparam logic [7:0] CHAR_EIGHT  = 8'h38;
  localparam logic [7:0] CHAR_EQUALS = 8'h3D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SOH    = 8'h01;

  // MsgType tag number.
  localparam logic [29:0] TAG_MSGTYPE = 30'd35;

  // Result queue geometry.
  localparam int unsigned RQ_DEPTH = 8;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_LVL_W = $clog2(RQ_DEPTH + 1);

  // Hot-tag slot of a tag number; zero for any tag outside the list.
  function automatic logic [4:0] hot_slot_of(input logic [29:0] tag);
    logic [4:0] slot;
    case (tag)
      30'd35:  slot = 5'd1;
      30'd49:  slot = 5'd2;
      30'd56:  slot = 5'd3;
      30'd34:  slot = 5'd4;
      30'd52:  slot = 5'd5;
      30'd11:  slot = 5'd6;
      30'd37:  slot = 5'd7;
      30'd17:  slot = 5'd8;
      30'd55:  slot = 5'd9;
      30'd54:  slot = 5'd10;
      30'd150: slot = 5'd11;
      30'd39:  slot = 5'd12;
      30'd44:  slot = 5'd13;
      30'd38:  slot = 5'd14;
      30'd14:  slot = 5'd15;
      30'd151: slot = 5'd16;
      30'd31:  slot = 5'd17;
      30'd32:  slot = 5'd18;
      30'd58:  slot = 5'd19;
      default: slot = 5'd0;
    endcase
    return slot;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fix_tag_value_tokenizer_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fix_tag_value_tokenizer_core
// Streaming FIX tag=value tokenizer: one message byte per input transfer,
// field and status results on the output channel.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one byte of the line per transfer, with a flag
// for a byte being present and a flag for the last item of the line. The
// output channel carries one result per transfer: a field result for each
// tag=value pair as it closes, and a status result on the last item.
// Configuration (delimiter, prefix reporting) is written through the plain
// write port while the block is idle.
// An accepted item is registered, parsed in the next cycle, and its results
// are written into the result queue, from which the output offers them.
// One item is accepted per cycle while the input is not stalled; the limit is
// the single output transfer per cycle, so an item that yields both a field
// and a status needs two output transfers. An eight-entry result queue absorbs these bursts.
// When the receiver stalls, results wait in the queue and the input stalls
// once the queue cannot take the worst case of the items in flight.
// Reset clears the parse state and the queue, sets the delimiter to SOH and
// turns prefix reporting off.
// ----------------------------------------------------------------------------
module fix_tag_value_tokenizer_core #(
  parameter int unsigned MAX_LINE_BYTES = 4096,
  parameter int unsigned MAX_TAG_DIGITS = 9
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  ftvt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ftvt_pkg::out_item_t out_data_o,
  input  wire                 cfg_we_i,
  input  wire                 cfg_index_i,
  input  wire [7:0]           cfg_data_i
);
  import ftvt_pkg::*;

  logic                item_vld_q;
  in_item_t            item_q;
  logic [7:0]          delim_q;
  logic                report_q;
  push_t               push;
  logic [RQ_LVL_W-1:0] level;
  logic [RQ_LVL_W:0]   committed;
  logic                in_take;

  // Queue space already promised: filled entries plus two for a held item.
  assign committed  = {1'b0, level} + (item_vld_q ? (RQ_LVL_W + 1)'(2) : '0);
  assign in_stall_o = (committed > (RQ_LVL_W + 1)'(RQ_DEPTH - 2));
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= CHAR_SOH;
      report_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIELD_DELIMITER: delim_q  <= cfg_data_i;
        CFG_REPORT_PREFIX:   report_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ftvt_parser #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES),
    .MAX_TAG_DIGITS (MAX_TAG_DIGITS)
  ) u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (item_vld_q),
    .item_i            (item_q),
    .field_delimiter_i (delim_q),
    .report_prefix_i   (report_q),
    .push_o            (push)
  );

  ftvt_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .level_o     (level)
  );

endmodule
`default_nettype wire

// ===== hdl/ftvt_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftvt_parser
// Running parse state of one message line. Each registered item updates the
// state and yields up to two results: a closed field and the end-of-message
// status.
// ----------------------------------------------------------------------------
module ftvt_parser #(
  parameter int unsigned MAX_LINE_BYTES = 4096,
  parameter int unsigned MAX_TAG_DIGITS = 9
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                item_valid_i,
  input  ftvt_pkg::in_item_t item_i,
  input  wire [7:0]          field_delimiter_i,
  input  wire                report_prefix_i,
  output ftvt_pkg::push_t    push_o
);
  import ftvt_pkg::*;

  localparam int unsigned PW = $clog2(MAX_LINE_BYTES + 1);
  localparam int unsigned CW = $clog2(MAX_TAG_DIGITS + 1);

  typedef enum logic [1:0] {
    PH_SEARCH,
    PH_TAG,
    PH_VALUE,
    PH_ERROR
  } phase_e;

  phase_e         phase_q, phase_d;
  logic           prev8_q, prev8_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [29:0]    acc_q, acc_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           bad_q, bad_d;
  logic           has_q, has_d;
  logic [PW-1:0]  vstart_q, vstart_d;
  logic [PW-1:0]  start_q, start_d;
  logic [11:0]    pair_q, pair_d;
  logic           msg_q, msg_d;
  logic [2:0]     err_q, err_d;

  logic [7:0]     b;
  logic           take;
  logic           emit;
  logic [PW-1:0]  end_pos;
  logic [PW-1:0]  len;
  logic [2:0]     status;
  logic [32:0]    acc_x10;

  // Position values are reported modulo 4096.
  function automatic logic [11:0] to12(input logic [PW-1:0] v);
    logic [PW+11:0] w;
    w = {12'b0, v};
    return w[11:0];
  endfunction

  assign b       = item_i.data_byte;
  assign take    = item_i.byte_present && (pos_q < PW'(MAX_LINE_BYTES));
  // Times ten as two shifted copies.
  assign acc_x10 = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0};

  // Next state and results of the registered item.
  always_comb begin
    phase_d  = phase_q;
    prev8_d  = prev8_q;
    pos_d    = pos_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    bad_d    = bad_q;
    has_d    = has_q;
    vstart_d = vstart_q;
    start_d  = start_q;
    pair_d   = pair_q;
    msg_d    = msg_q;
    err_d    = err_q;
    emit     = 1'b0;
    end_pos  = pos_q;
    len      = '0;
    status   = ST_OK;
    push_o   = '0;

    if (item_valid_i && take) begin
      pos_d = pos_q + PW'(1);
      case (phase_q)
        PH_SEARCH: begin
          if (prev8_q && (b == CHAR_EQUALS)) begin
            // The "8=" of the start also goes through the pair logic.
            start_d  = pos_q - PW'(1);
            acc_d    = '0;
            cnt_d    = '0;
            bad_d    = 1'b0;
            has_d    = 1'b0;
            vstart_d = '0;
            if (field_delimiter_i == CHAR_EIGHT) begin
              // The '8' is a delimiter, so the '=' finds an empty tag.
              phase_d = PH_ERROR;
              err_d   = ST_BAD_TAG;
            end else if (field_delimiter_i == CHAR_EQUALS) begin
              // The '=' is a delimiter closing a pair that has no '='.
              acc_d   = 30'd8;
              cnt_d   = CW'(1);
              has_d   = 1'b1;
              phase_d = PH_ERROR;
              err_d   = ST_NO_EQUALS;
            end else begin
              acc_d    = 30'd8;
              cnt_d    = CW'(1);
              has_d    = 1'b1;
              phase_d  = PH_VALUE;
              vstart_d = pos_q + PW'(1);
            end
          end else begin
            prev8_d = (b == CHAR_EIGHT);
          end
        end
        PH_TAG: begin
          if (b == field_delimiter_i) begin
            if (has_q) begin
              phase_d = PH_ERROR;
              err_d   = ST_NO_EQUALS;
            end
          end else if (b == CHAR_EQUALS) begin
            if (bad_q || (cnt_q == '0)) begin
              phase_d = PH_ERROR;
              err_d   = ST_BAD_TAG;
            end else begin
              phase_d  = PH_VALUE;
              vstart_d = pos_q + PW'(1);
            end
          end else begin
            has_d = 1'b1;
            if ((b >= CHAR_ZERO) && (b <= CHAR_NINE) && (cnt_q < CW'(MAX_TAG_DIGITS))) begin
              acc_d = acc_x10[29:0] + {26'b0, b[3:0]};
              cnt_d = cnt_q + CW'(1);
            end else begin
              bad_d = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          if (b == field_delimiter_i) begin
            emit    = 1'b1;
            end_pos = pos_q;
          end
        end
        default: ;
      endcase
    end

    // A value still open at the end of the line closes there.
    if (item_valid_i && item_i.end_of_message && !emit && (phase_d == PH_VALUE)) begin
      emit    = 1'b1;
      end_pos = pos_d;
    end

    // Close the current pair into a field result.
    if (emit) begin
      len                       = end_pos - vstart_d;
      push_o.fld_vld            = 1'b1;
      push_o.fld.result_kind    = KIND_FIELD;
      push_o.fld.tag_number     = acc_d;
      push_o.fld.hot_slot       = hot_slot_of(acc_d);
      push_o.fld.value_offset   = to12(vstart_d);
      push_o.fld.value_length   = to12(len);
      if (acc_d == TAG_MSGTYPE) begin
        msg_d = (len != '0);
      end
      if (pair_d != 12'hFFF) begin
        pair_d = pair_d + 12'd1;
      end
      phase_d  = PH_TAG;
      acc_d    = '0;
      cnt_d    = '0;
      bad_d    = 1'b0;
      has_d    = 1'b0;
      vstart_d = '0;
    end

    // End of line: status result, then a fresh message.
    if (item_valid_i && item_i.end_of_message) begin
      if ((phase_d == PH_TAG) && has_d) begin
        phase_d = PH_ERROR;
        err_d   = ST_NO_EQUALS;
      end
      if (pos_d == '0) begin
        status = ST_EMPTY;
      end else if (phase_d == PH_SEARCH) begin
        status = ST_NO_START;
      end else if (phase_d == PH_ERROR) begin
        status = err_d;
      end else if (pair_d == '0) begin
        status = ST_NO_TAGS;
      end else if (!msg_d) begin
        status = ST_NO_MSGTYPE;
      end else begin
        status = ST_OK;
      end
      push_o.sts_vld             = 1'b1;
      push_o.sts.result_kind     = KIND_STATUS;
      push_o.sts.status_code     = status;
      push_o.sts.prefix_length   = (report_prefix_i && (phase_d != PH_SEARCH)) ?
                                   to12(start_d) : 12'd0;
      push_o.sts.field_count     = pair_d;
      push_o.sts.last_result     = 1'b1;

      phase_d  = PH_SEARCH;
      prev8_d  = 1'b0;
      pos_d    = '0;
      acc_d    = '0;
      cnt_d    = '0;
      bad_d    = 1'b0;
      has_d    = 1'b0;
      vstart_d = '0;
      start_d  = '0;
      pair_d   = '0;
      msg_d    = 1'b0;
      err_d    = ST_OK;
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      prev8_q  <= 1'b0;
      pos_q    <= '0;
      acc_q    <= '0;
      cnt_q    <= '0;
      bad_q    <= 1'b0;
      has_q    <= 1'b0;
      vstart_q <= '0;
      start_q  <= '0;
      pair_q   <= '0;
      msg_q    <= 1'b0;
      err_q    <= ST_OK;
    end else begin
      phase_q  <= phase_d;
      prev8_q  <= prev8_d;
      pos_q    <= pos_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      bad_q    <= bad_d;
      has_q    <= has_d;
      vstart_q <= vstart_d;
      start_q  <= start_d;
      pair_q   <= pair_d;
      msg_q    <= msg_d;
      err_q    <= err_d;
    end
  end

`ifndef SYNTHESIS
  // A status result comes only from an end-of-message item.
  a_status_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.sts_vld |-> (item_valid_i && item_i.end_of_message))
    else $error("status result without end of message");

  // After a status result the next line starts from a clean state.
  a_clean_after_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.sts_vld |=> ((phase_q == PH_SEARCH) && (pos_q == '0) && (pair_q == '0)))
    else $error("message state not cleared after status");

  // A field closed mid-line leaves the parser reading the next tag.
  a_tag_after_field : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.fld_vld && !push_o.sts_vld) |=> (phase_q == PH_TAG) && !has_q)
    else $error("parser not in tag phase after a field");
`endif

endmodule
`default_nettype wire

// ===== hdl/ftvt_result_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftvt_result_fifo
// Result queue between the parser and the output channel. Takes up to two
// results per cycle and delivers one per transfer, oldest first.
// ----------------------------------------------------------------------------
module ftvt_result_fifo (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ftvt_pkg::push_t              push_i,
  input  wire                          out_stall_i,
  output logic                         out_valid_o,
  output ftvt_pkg::out_item_t          out_data_o,
  output logic [ftvt_pkg::RQ_LVL_W-1:0] level_o
);
  import ftvt_pkg::*;

  out_item_t             mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wr_q, wr_d;
  logic [RQ_PTR_W-1:0]   rd_q, rd_d;
  logic [RQ_LVL_W-1:0]   level_q, level_d;
  logic [RQ_PTR_W-1:0]   sts_addr;
  logic [1:0]            n_push;
  logic                  pop;

  assign out_valid_o = (level_q != '0);
  assign out_data_o  = mem[rd_q];
  assign level_o     = level_q;
  assign pop         = out_valid_o && !out_stall_i;
  assign n_push      = {1'b0, push_i.fld_vld} + {1'b0, push_i.sts_vld};
  assign sts_addr    = push_i.fld_vld ? (wr_q + RQ_PTR_W'(1)) : wr_q;

  // Pointer and fill level updates.
  always_comb begin
    wr_d    = wr_q + RQ_PTR_W'(n_push);
    rd_d    = pop ? (rd_q + RQ_PTR_W'(1)) : rd_q;
    level_d = level_q + RQ_LVL_W'(n_push) - RQ_LVL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      level_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      level_q <= level_d;
    end
  end

  // Storage; the field goes ahead of the status of the same item.
  always_ff @(posedge clk_i) begin
    if (push_i.fld_vld) begin
      mem[wr_q] <= push_i.fld;
    end
    if (push_i.sts_vld) begin
      mem[sts_addr] <= push_i.sts;
    end
  end

`ifndef SYNTHESIS
  // The fill level stays within the queue depth.
  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= RQ_LVL_W'(RQ_DEPTH))
    else $error("result queue level beyond depth");

  // A full queue is never written.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == RQ_LVL_W'(RQ_DEPTH)) |-> (n_push == 2'd0))
    else $error("result queue overflow");

  // A stalled result keeps its place and its contents.
  a_hold_while_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== tb/fix_tag_value_tokenizer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fix_tag_value_tokenizer_core_tb
// Self-checking testbench for the streaming FIX tokenizer. Message lines are
// fed one byte per transfer. A behavioral tokenizer in the bench predicts
// every field and status result, and each result transfer is checked field
// by field against the oldest prediction. Directed lines cover the status
// codes and the delimiter corner cases. Random lines run under several
// sender and receiver idling mixes, and an output hold-off fills the block.
// ----------------------------------------------------------------------------
module fix_tag_value_tokenizer_core_tb;
  import ftvt_pkg::*;

  localparam int unsigned LINE_LIMIT       = 4096;
  localparam int unsigned TAG_DIGIT_LIMIT  = 9;
  localparam int unsigned DRAIN_CYCLES     = 12;
  localparam int unsigned REPORT_LIMIT     = 10;
  localparam int unsigned ITEMS_PER_PHASE  = 215;
  localparam int unsigned HOLD_OFF_CYCLES  = 150;
  localparam logic [7:0]  DELIM_MARK       = 8'h7C;

  typedef enum logic [1:0] {
    PHASE_SEARCH,
    PHASE_TAG,
    PHASE_VALUE,
    PHASE_ERROR
  } parse_phase_e;

  // Block ports; every input starts at a known value.
  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_index_i = CFG_FIELD_DELIMITER;
  logic [7:0] cfg_data_i = '0;

  // Traffic shaping.
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;

  // Run bookkeeping.
  int items_sent         = 0;
  int lines_sent         = 0;
  int fields_checked     = 0;
  int statuses_checked   = 0;
  int mismatches         = 0;
  int input_stall_cycles = 0;

  // Results predicted but not yet seen on the output.
  out_item_t expected_tokens[$];

  // Bytes of the line being assembled.
  logic [7:0] line_buf[$];

  int unsigned hot_tags [19] = '{35, 49, 56, 34, 52, 11, 37, 17, 55, 54,
                                 150, 39, 44, 38, 14, 151, 31, 32, 58};

  // Tokenizer state of the bench's own prediction.
  logic [7:0]   delim;
  logic         report_on;
  parse_phase_e phase;
  logic         saw_eight;
  logic [31:0]  line_pos;
  logic [31:0]  tag_value;
  logic [31:0]  tag_digits;
  logic         tag_invalid;
  logic         pair_nonempty;
  logic [31:0]  value_begin;
  logic [31:0]  start_pos;
  logic [31:0]  pairs_parsed;
  logic         msgtype_ok;
  logic [2:0]   first_error;

  fix_tag_value_tokenizer_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [4:0] hot_tag_slot(input logic [31:0] tag);
    int k;
    for (k = 0; k < 19; k++) begin
      if (hot_tags[k] == tag) return 5'(k + 1);
    end
    return 5'd0;
  endfunction

  function automatic void clear_pair_state();
    tag_value     = '0;
    tag_digits    = '0;
    tag_invalid   = 1'b0;
    pair_nonempty = 1'b0;
    value_begin   = '0;
  endfunction

  function automatic void clear_line_state();
    phase        = PHASE_SEARCH;
    saw_eight    = 1'b0;
    line_pos     = '0;
    start_pos    = '0;
    pairs_parsed = '0;
    msgtype_ok   = 1'b0;
    first_error  = ST_OK;
    clear_pair_state();
  endfunction

  function automatic void fail_line(input logic [2:0] code);
    phase       = PHASE_ERROR;
    first_error = code;
  endfunction

  // A pair closes: predict its field result.
  function automatic void close_field(input logic [31:0] end_pos);
    out_item_t   tok;
    logic [31:0] len;
    len = end_pos - value_begin;
    tok = '0;
    tok.result_kind  = KIND_FIELD;
    tok.tag_number   = tag_value[29:0];
    tok.hot_slot     = hot_tag_slot(tag_value);
    tok.value_offset = value_begin[11:0];
    tok.value_length = len[11:0];
    expected_tokens.insert(expected_tokens.size(), tok);
    if (tag_value == 32'(TAG_MSGTYPE)) msgtype_ok = (len != 0);
    if (pairs_parsed < 32'hFFF) pairs_parsed++;
    phase = PHASE_TAG;
    clear_pair_state();
  endfunction

  // One byte through the pair logic; the delimiter is checked before '='.
  function automatic void pair_byte(input logic [7:0] b, input logic [31:0] p);
    case (phase)
      PHASE_TAG: begin
        if (b == delim) begin
          if (pair_nonempty) fail_line(ST_NO_EQUALS);
        end else if (b == CHAR_EQUALS) begin
          if (tag_invalid || tag_digits == 0) begin
            fail_line(ST_BAD_TAG);
          end else begin
            phase       = PHASE_VALUE;
            value_begin = p + 1;
          end
        end else begin
          pair_nonempty = 1'b1;
          if (b >= CHAR_ZERO && b <= CHAR_NINE && tag_digits < TAG_DIGIT_LIMIT) begin
            tag_value = tag_value * 10 + 32'(b - CHAR_ZERO);
            tag_digits++;
          end else begin
            tag_invalid = 1'b1;
          end
        end
      end
      PHASE_VALUE: begin
        if (b == delim) close_field(p);
      end
      default: ;
    endcase
  endfunction

  // Look for the first "8=", then hand both of its bytes to the pair logic.
  function automatic void take_byte(input logic [7:0] b);
    logic [31:0] p;
    p = line_pos;
    if (phase == PHASE_SEARCH) begin
      if (saw_eight && b == CHAR_EQUALS) begin
        start_pos = p - 1;
        phase     = PHASE_TAG;
        clear_pair_state();
        pair_byte(CHAR_EIGHT, p - 1);
        pair_byte(CHAR_EQUALS, p);
      end else begin
        saw_eight = (b == CHAR_EIGHT);
      end
    end else begin
      pair_byte(b, p);
    end
  endfunction

  // End of line: close a pending pair and predict the status result.
  function automatic void close_line();
    out_item_t  tok;
    logic [2:0] code;
    if (phase == PHASE_VALUE) close_field(line_pos);
    else if (phase == PHASE_TAG && pair_nonempty) fail_line(ST_NO_EQUALS);

    if (line_pos == 0)              code = ST_EMPTY;
    else if (phase == PHASE_SEARCH) code = ST_NO_START;
    else if (phase == PHASE_ERROR)  code = first_error;
    else if (pairs_parsed == 0)     code = ST_NO_TAGS;
    else if (!msgtype_ok)           code = ST_NO_MSGTYPE;
    else                            code = ST_OK;

    tok = '0;
    tok.result_kind   = KIND_STATUS;
    tok.status_code   = code;
    tok.prefix_length = (report_on && phase != PHASE_SEARCH) ? start_pos[11:0] : 12'd0;
    tok.field_count   = pairs_parsed[11:0];
    tok.last_result   = 1'b1;
    expected_tokens.insert(expected_tokens.size(), tok);
  endfunction

  function automatic void tokenize_item(input in_item_t it);
    if (it.byte_present && line_pos < LINE_LIMIT) begin
      take_byte(it.data_byte);
      line_pos++;
    end
    if (it.end_of_message) begin
      close_line();
      clear_line_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and result checking
  // ---------------------------------------------------------------------------

  // A hold-off count takes priority over the random stall pattern.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i = 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i = ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic string token_text(input out_item_t t);
    return $sformatf("kind=%0d tag=%0d hot=%0d off=%0d len=%0d sts=%0d pfx=%0d cnt=%0d last=%0d",
                     t.result_kind, t.tag_number, t.hot_slot, t.value_offset,
                     t.value_length, t.status_code, t.prefix_length, t.field_count,
                     t.last_result);
  endfunction

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_tokens
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: %s", token_text(out_data_o));
      end else begin
        want = expected_tokens.pop_front();
        if (want.result_kind == KIND_FIELD) fields_checked++;
        else statuses_checked++;
        if (want.result_kind   !== out_data_o.result_kind   ||
            want.tag_number    !== out_data_o.tag_number    ||
            want.hot_slot      !== out_data_o.hot_slot      ||
            want.value_offset  !== out_data_o.value_offset  ||
            want.value_length  !== out_data_o.value_length  ||
            want.status_code   !== out_data_o.status_code   ||
            want.prefix_length !== out_data_o.prefix_length ||
            want.field_count   !== out_data_o.field_count   ||
            want.last_result   !== out_data_o.last_result) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("mismatch at %0t ns", $realtime);
            $display("  expected %s", token_text(want));
            $display("  actual   %s", token_text(out_data_o));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one item, idling first at random, and wait for its transfer.
  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (in_stall_o) begin
      input_stall_cycles++;
      @(posedge clk_i);
    end
    tokenize_item(it);
    if (it.byte_present || it.end_of_message) items_sent++;
  endtask

  // Drop valid, wait for every predicted result, then let the pipe drain.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Registers are only written with the block idle.
  task automatic write_register(input logic idx, input logic [7:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_FIELD_DELIMITER) delim = value;
    else report_on = value[0];
  endtask

  function automatic void set_traffic(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
  endfunction

  // Append text; a '|' stands for the current delimiter.
  function automatic void put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++)
      line_buf.insert(line_buf.size(), (s[i] == DELIM_MARK) ? delim : s[i]);
  endfunction

  function automatic logic [7:0] value_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == delim);
    return b;
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0:       return CHAR_EIGHT;
      1:       return CHAR_EQUALS;
      2:       return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
      3:       return delim;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] random_delimiter();
    logic [7:0] d;
    do d = 8'($urandom_range(0, 255));
    while ((d >= CHAR_ZERO && d <= CHAR_NINE) || d == CHAR_EQUALS);
    return d;
  endfunction

  // Send the assembled line; the end marker rides on the last byte or
  // comes as a separate item without a byte.
  task automatic send_line(input bit bare_end);
    in_item_t it;
    int       i;
    for (i = 0; i < line_buf.size(); i++) begin
      it.data_byte      = line_buf[i];
      it.byte_present   = 1'b1;
      it.end_of_message = !bare_end && (i == line_buf.size() - 1);
      send_item(it);
    end
    if (bare_end || line_buf.size() == 0) begin
      it.data_byte      = 8'($urandom_range(0, 255));
      it.byte_present   = 1'b0;
      it.end_of_message = 1'b1;
      send_item(it);
    end
    line_buf.delete();
    lines_sent++;
  endtask

  // Mostly well-formed lines with random tags and values; some are noise
  // or carry a broken pair.
  task automatic build_random_line(output bit bare_end);
    int          n;
    int          k;
    int          pick;
    logic [31:0] tag;
    string       digits;
    line_buf.delete();
    bare_end = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 14)) line_buf.insert(line_buf.size(), noise_byte());
      return;
    end
    repeat ($urandom_range(0, 3)) line_buf.insert(line_buf.size(), noise_byte());
    put_text("8=FIX.4.4|");
    if ($urandom_range(0, 99) < 75) begin
      put_text("35=");
      repeat ($urandom_range(0, 2)) line_buf.insert(line_buf.size(), value_byte());
      put_text("|");
    end
    n = $urandom_range(0, 7);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      tag = hot_tags[$urandom_range(0, 18)];
      else if (pick < 75) tag = $urandom_range(0, 199);
      else                tag = $urandom_range(1, 999999999);
      digits = $sformatf("%0d", tag);
      pick = $urandom_range(0, 99);
      if (pick < 4)      digits = $sformatf("1%09d", $urandom_range(0, 999999999));
      else if (pick < 7) digits = {digits, "x"};
      else if (pick < 9) digits = "";
      put_text(digits);
      if ($urandom_range(0, 99) >= 3) put_text("=");
      if ($urandom_range(0, 99) >= 10)
        repeat ($urandom_range(1, 8)) line_buf.insert(line_buf.size(), value_byte());
      put_text("|");
      if ($urandom_range(0, 99) < 8) put_text("|");
    end
    // Sometimes the line ends inside the last value instead of on a delimiter.
    if (!bare_end && $urandom_range(0, 1) && line_buf[$] == delim) void'(line_buf.pop_back());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every status code that can occur, with the default delimiter.
  task automatic test_directed_lines();
    set_traffic(0, 0);
    send_line(1);
    put_text("ab8x");                  send_line(0);
    put_text("8=FIX.4.4|9=12|35=A|");  send_line(0);
    put_text("X8=F|35=D");             send_line(1);
    put_text("8=F|abc|");              send_line(0);
    put_text("8=F|1x=2|5=6|");         send_line(0);
    put_text("8=F|=2|");               send_line(0);
    put_text("8=F|1234567890=2|");     send_line(0);
    put_text("8=F|999999999=");
    line_buf.insert(line_buf.size(), 8'h00);
    line_buf.insert(line_buf.size(), 8'hFF);
    put_text("||35=|");                send_line(0);
    put_text("8=F|35=|35=A");          send_line(0);
    put_text("8=F|35=A|35=|");         send_line(0);
    put_text("8=F|35=A|12");           send_line(1);
    settle();
  endtask

  // Each known tag gets its slot; neighbors of known tags get none.
  task automatic test_hot_tags();
    int k;
    set_traffic(0, 0);
    put_text("8=F|");
    for (k = 0; k < 19; k++) put_text($sformatf("%0d=v|", hot_tags[k]));
    put_text("36=|0=z|152=q|");
    send_line(0);
    settle();
  endtask

  // Delimiters that collide with the start bytes, and the byte extremes.
  task automatic test_delimiter_settings();
    set_traffic(0, 0);
    write_register(CFG_REPORT_PREFIX, 8'd1);
    write_register(CFG_FIELD_DELIMITER, CHAR_EQUALS);
    put_text("zz8=F=35=A=");           send_line(0);
    write_register(CFG_FIELD_DELIMITER, CHAR_EIGHT);
    put_text("q8=35=A|");              send_line(0);
    write_register(CFG_FIELD_DELIMITER, 8'h00);
    put_text("88=F|35=A|");            send_line(1);
    write_register(CFG_FIELD_DELIMITER, 8'hFF);
    put_text("a8=F|35=B|58=x");        send_line(0);
    put_text("nostart");               send_line(0);
    write_register(CFG_REPORT_PREFIX, 8'd0);
    write_register(CFG_FIELD_DELIMITER, CHAR_SOH);
    put_text("pp8=F|35=A|");           send_line(0);
    settle();
  endtask

  task automatic test_random_traffic(input int idle, input int stall,
                                     input logic [7:0] d, input logic pfx);
    int       first_item;
    bit       bare_end;
    in_item_t blank;
    write_register(CFG_FIELD_DELIMITER, d);
    write_register(CFG_REPORT_PREFIX, {7'd0, pfx});
    set_traffic(idle, stall);
    first_item = items_sent;
    while (items_sent - first_item < ITEMS_PER_PHASE) begin
      // An item with neither byte nor end marker is ignored by the block.
      if ($urandom_range(0, 99) < 3) begin
        blank.data_byte      = 8'($urandom_range(0, 255));
        blank.byte_present   = 1'b0;
        blank.end_of_message = 1'b0;
        send_item(blank);
      end
      build_random_line(bare_end);
      send_line(bare_end);
    end
    settle();
  endtask

  // Hold the output off while a field-dense line streams in, so the result
  // queue fills and the input stalls.
  task automatic test_output_hold_off();
    set_traffic(0, 0);
    hold_cycles = HOLD_OFF_CYCLES;
    put_text("8=F|35=A|");
    repeat (40) put_text("1=a|");
    send_line(0);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    delim     = CHAR_SOH;
    report_on = 1'b0;
    clear_line_state();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_lines();
    test_hot_tags();
    test_delimiter_settings();
    test_random_traffic(0, 0, CHAR_SOH, 1'b0);
    test_random_traffic(54, 0, DELIM_MARK, 1'b1);
    test_random_traffic(0, 54, 8'hFF, 1'b0);
    test_random_traffic(22, 22, random_delimiter(), 1'b1);
    test_output_hold_off();

    if (expected_tokens.size() != 0) mismatches += expected_tokens.size();
    $display("sent %0d items in %0d lines; checked %0d field and %0d status results",
             items_sent, lines_sent, fields_checked, statuses_checked);
    $display("input stalled %0d cycles; %0d mismatches", input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("fix_tag_value_tokenizer_core_tb: clean");
    end else begin
      $display("fix_tag_value_tokenizer_core_tb: errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("fix_tag_value_tokenizer_core_tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ftvt_pkg.sv
hdl/ftvt_parser.sv
hdl/ftvt_result_fifo.sv
hdl/fix_tag_value_tokenizer_core.sv
tb/fix_tag_value_tokenizer_core_tb.sv
